// ===== rtl/core/pfe_pkg.sv =====
// Shared types, codes and sizing constants of the postfix fraction evaluator.
package pfe_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DEPTH_W     = 5;
    localparam int FRAC_W      = 32;
    localparam int RAM_DEPTH   = STACK_DEPTH - 2;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);
    localparam int RAM_W       = 2 * FRAC_W;

    typedef enum logic [2:0] {
        KIND_PUSH = 3'd0,
        KIND_ADD  = 3'd1,
        KIND_SUB  = 3'd2,
        KIND_MUL  = 3'd3,
        KIND_DIV  = 3'd4
    } kind_e;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_e;

    typedef enum logic [1:0] {
        MUL_LEFT  = 2'd0,
        MUL_BC    = 2'd1,
        MUL_BD    = 2'd2
    } mul_sel_e;

    typedef struct packed {
        logic [2:0]               kind;
        logic signed [FRAC_W-1:0] push_numerator;
        logic signed [FRAC_W-1:0] push_denominator;
    } in_req_t;

    typedef struct packed {
        logic signed [FRAC_W-1:0] top_numerator;
        logic signed [FRAC_W-1:0] top_denominator;
        logic [DEPTH_W-1:0]       stack_depth;
        logic [1:0]               status;
    } out_rsp_t;

    typedef struct packed {
        logic     load_token;
        logic     decode;
        logic     mul_en;
        mul_sel_e mul_sel;
        logic     combine;
        logic     fill;
        logic     load_out;
    } pfe_cmd_t;

    typedef struct packed {
        logic op_go;
    } pfe_stat_t;

endpackage

// ===== rtl/core/pfe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/pfe_datapath.sv =====
// Datapath: cached top two stack entries, deeper entries in RAM, shared multiplier.
module pfe_datapath import pfe_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_req_t   s_payload,
    input  pfe_cmd_t  cmd,
    output pfe_stat_t stat,
    output out_rsp_t  m_payload
);

    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_TWO  = DEPTH_W'(2);
    localparam logic [DEPTH_W-1:0] DEPTH_THREE = DEPTH_W'(3);

    in_req_t            tok_reg, tok_next;
    logic [FRAC_W-1:0]  top_n_reg, top_n_next, top_d_reg, top_d_next;
    logic [FRAC_W-1:0]  nxt_n_reg, nxt_n_next, nxt_d_reg, nxt_d_next;
    logic [FRAC_W-1:0]  p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [1:0]         status_reg, status_next;
    out_rsp_t           out_reg, out_next;

    logic [FRAC_W-1:0]  mul_a, mul_b, prod;
    logic [FRAC_W-1:0]  res_n, res_d;
    logic [DEPTH_W-1:0] push_slot, refill_slot;
    logic               ram_we;
    logic [RAM_W-1:0]   ram_rdata;
    logic               is_op, ge2, full;

    assign push_slot   = depth_reg - DEPTH_TWO;
    assign refill_slot = depth_reg - DEPTH_THREE;
    assign ge2         = depth_reg >= DEPTH_TWO;
    assign full        = depth_reg >= DEPTH_FULL;
    assign is_op       = (tok_reg.kind != KIND_PUSH) && (tok_reg.kind <= KIND_DIV);
    assign stat.op_go  = is_op && ge2;

    pfe_ram #(
        .WIDTH (RAM_W),
        .DEPTH (RAM_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (push_slot[RAM_AW-1:0]),
        .wdata ({nxt_n_reg, nxt_d_reg}),
        .raddr (refill_slot[RAM_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Left operand is a/b (second entry), right operand is c/d (top entry).
    always_comb begin
        unique case (cmd.mul_sel)
            MUL_LEFT: begin
                mul_a = nxt_n_reg;
                mul_b = (tok_reg.kind == KIND_MUL) ? top_n_reg : top_d_reg;
            end
            MUL_BC: begin
                mul_a = nxt_d_reg;
                mul_b = top_n_reg;
            end
            MUL_BD: begin
                mul_a = nxt_d_reg;
                mul_b = top_d_reg;
            end
            default: begin
                mul_a = nxt_d_reg;
                mul_b = top_d_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb begin
        unique case (tok_reg.kind)
            KIND_ADD: begin
                if (nxt_d_reg == top_d_reg) begin
                    res_n = nxt_n_reg + top_n_reg;
                    res_d = nxt_d_reg;
                end else begin
                    res_n = p0_reg + p1_reg;
                    res_d = p2_reg;
                end
            end
            KIND_SUB: begin
                if (nxt_d_reg == top_d_reg) begin
                    res_n = nxt_n_reg - top_n_reg;
                    res_d = nxt_d_reg;
                end else begin
                    res_n = p0_reg - p1_reg;
                    res_d = p2_reg;
                end
            end
            KIND_MUL: begin
                res_n = p0_reg;
                res_d = p2_reg;
            end
            default: begin
                res_n = p0_reg;
                res_d = p1_reg;
            end
        endcase
    end

    always_comb begin
        tok_next    = tok_reg;
        top_n_next  = top_n_reg;
        top_d_next  = top_d_reg;
        nxt_n_next  = nxt_n_reg;
        nxt_d_next  = nxt_d_reg;
        p0_next     = p0_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        depth_next  = depth_reg;
        status_next = status_reg;
        out_next    = out_reg;
        ram_we      = 1'b0;

        if (cmd.load_token) begin
            tok_next = s_payload;
        end

        if (cmd.decode) begin
            status_next = ST_OK;
            if (tok_reg.kind == KIND_PUSH) begin
                if (full) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    ram_we     = ge2;
                    nxt_n_next = top_n_reg;
                    nxt_d_next = top_d_reg;
                    top_n_next = tok_reg.push_numerator;
                    top_d_next = tok_reg.push_denominator;
                    depth_next = depth_reg + DEPTH_W'(1);
                end
            end else if (is_op && !ge2) begin
                status_next = ST_UNDERFLOW;
            end
        end

        if (cmd.mul_en) begin
            unique case (cmd.mul_sel)
                MUL_LEFT: p0_next = prod;
                MUL_BC:   p1_next = prod;
                MUL_BD:   p2_next = prod;
                default:  p2_next = prod;
            endcase
        end

        if (cmd.combine) begin
            top_n_next = res_n;
            top_d_next = res_d;
            depth_next = depth_reg - DEPTH_W'(1);
        end

        if (cmd.fill && ge2) begin
            nxt_n_next = ram_rdata[RAM_W-1:FRAC_W];
            nxt_d_next = ram_rdata[FRAC_W-1:0];
        end

        if (cmd.load_out) begin
            if (depth_reg == '0) begin
                out_next.top_numerator   = '0;
                out_next.top_denominator = '0;
            end else begin
                out_next.top_numerator   = top_n_reg;
                out_next.top_denominator = top_d_reg;
            end
            out_next.stack_depth = depth_reg;
            out_next.status      = status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
        tok_reg    <= tok_next;
        top_n_reg  <= top_n_next;
        top_d_reg  <= top_d_next;
        nxt_n_reg  <= nxt_n_next;
        nxt_d_reg  <= nxt_d_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign m_payload = out_reg;

endmodule

// ===== rtl/core/pfe_controller.sv =====
// Controller: one-hot state machine sequencing each request through the datapath.
module pfe_controller import pfe_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  pfe_stat_t stat,
    output pfe_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DECODE  = 8'b0000_0010,
        S_MUL0    = 8'b0000_0100,
        S_MUL1    = 8'b0000_1000,
        S_MUL2    = 8'b0001_0000,
        S_COMBINE = 8'b0010_0000,
        S_FILL    = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   out_free;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.mul_sel    = MUL_LEFT;
        s_ready        = 1'b0;
        valid_next     = valid_reg && !m_ready;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_token = 1'b1;
                    state_next     = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                state_next = stat.op_go ? S_MUL0 : S_DONE;
            end
            S_MUL0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LEFT;
                state_next  = S_MUL1;
            end
            S_MUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BC;
                state_next  = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BD;
                state_next  = S_COMBINE;
            end
            S_COMBINE: begin
                cmd.combine = 1'b1;
                state_next  = S_FILL;
            end
            S_FILL: begin
                cmd.fill   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid = valid_reg;

endmodule

// ===== rtl/core/postfix_fraction_evaluator_unit.sv =====
// Top level of the postfix fraction evaluator: controller, datapath and checks.
//
// This block evaluates postfix expressions over fractions. Each request either
// pushes a fraction (numerator, denominator) or applies add, subtract, multiply
// or divide to the two top stack entries, the second-from-top entry being the
// left operand; all arithmetic wraps at 32 bits. Every request produces exactly
// one response carrying the top entry (zero when the stack is empty), the depth
// and a status: ok, underflow (operator with fewer than two entries, ignored) or
// overflow (push onto a full stack of sixteen, ignored). Requests are handled
// one at a time. A push, an ignored request or an unused kind code goes from
// decode straight to the done state; an operator first passes through the
// multiply steps, the combine step and the refill step. In the done state the
// response is loaded once the output register is free. The operator time is set
// by the single shared 32 by 32 multiplier that forms three partial products in
// turn and by the registered read of the stack memory that refills the second
// entry after a pop. The response sits in an output register, so the next
// request is taken while the previous response still waits on m_ready. The
// stack memory needs no clearing after reset.
module postfix_fraction_evaluator_unit import pfe_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_req_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output out_rsp_t m_payload
);

    pfe_cmd_t  cmd;
    pfe_stat_t stat;

    // The controller walks each request through decode and, for an operator, the
    // multiply steps, the combine step and the refill of the second entry.
    pfe_controller u_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath keeps the two top entries in registers and spills deeper
    // entries to a small RAM, so an operator only ever needs one RAM read.
    pfe_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_payload (m_payload)
    );

`ifndef SYNTHESIS
    // A new request is never taken in the cycle right after one was accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous one still in progress");

    // An empty stack reports a zero fraction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.stack_depth == '0) |->
            (m_payload.top_numerator == '0) && (m_payload.top_denominator == '0))
        else $error("empty stack reported a nonzero top entry");

    // Underflow can only be reported with fewer than two entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status == ST_UNDERFLOW) |->
            (m_payload.stack_depth < DEPTH_W'(2)))
        else $error("underflow reported with two or more entries");

    // Overflow can only be reported on a full stack, and depth never exceeds it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.stack_depth <= DEPTH_W'(STACK_DEPTH)) &&
            ((m_payload.status != ST_OVERFLOW) ||
             (m_payload.stack_depth == DEPTH_W'(STACK_DEPTH))))
        else $error("stack depth or overflow status inconsistent");
`endif

endmodule
